@@ src/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the tick timebase
// Request codes, register indexes, reset values and the interface structs
// between the timebase control and the serial remainder unit.
// ----------------------------------------------------------------------------
package ttb_pkg;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_READ_SUB    = 3'd1,
    REQ_READ_SEC    = 3'd2,
    REQ_RELEASE_ONE = 3'd3,
    REQ_RELEASE_ALL = 3'd4,
    REQ_WRITE_SUB   = 3'd5,
    REQ_WRITE_SEC   = 3'd6,
    REQ_SAFE_RESET  = 3'd7
  } req_code_t;

  typedef enum logic {
    CFG_TICKS_PER_SECOND = 1'b0,
    CFG_DAY_LIMIT        = 1'b1
  } cfg_index_t;

  localparam logic [15:0] TPS_RESET       = 16'd50;
  localparam logic [31:0] DAY_LIMIT_RESET = 32'd86400000;
  localparam logic [5:0]  TOKEN_MAX       = 6'h3F;

  localparam int unsigned DVD_W = 32;
  localparam int unsigned DVS_W = 16;

  // Command into the remainder unit.
  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } mod_cmd_t;

  // Status back from the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } mod_status_t;

endpackage

@@ src/ttb_mod_unit.sv @@
// ----------------------------------------------------------------------------
// ttb_mod_unit: serial 32-by-16 remainder
// Restoring division, one dividend bit per cycle; reports whether the
// remainder is zero with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module ttb_mod_unit
  import ttb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mod_cmd_t    cmd,
  output mod_status_t status
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem, dvd[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd <= cmd.dividend;
      dvs <= cmd.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      // keep the subtraction when the trial value covers the divisor
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[DVS_W-1:0];
      end else begin
        rem <= trial[DVS_W-1:0];
      end
    end
  end

  assign status.busy     = busy;
  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

@@ src/tick_timebase_with_guarded_reset_unit.sv @@
// ----------------------------------------------------------------------------
// tick_timebase_with_guarded_reset_unit: sub-second / seconds timebase
// Tick counter with seconds rollover, read tokens and a guarded safe reset.
// ----------------------------------------------------------------------------
// One request is in flight at a time. For a tick request, the new sub-second
// count is divided by ticks_per_second in a serial remainder unit that
// retires one dividend bit per cycle; it starts at acceptance, its remainder
// is picked up when it is done, then the state is committed and the result
// register loaded. All other requests go from acceptance straight to commit.
// in_stall is high from acceptance until the result is committed; the result
// register then holds the result until out_stall drops, while the next
// request may already be accepted. A commit waits only if the result
// register is still occupied. Reads take a token (saturating at 63); release
// requests return one or all. A tick that lands on a second boundary with
// the sub-second count above day_limit raises reset_pending; a safe reset
// request clears the sub-second count and the pending flag only when one is
// pending and no tokens are held. Configuration (index 0 ticks_per_second,
// index 1 day_limit) is written through cfg_write/cfg_index/cfg_data; the
// user must do this only while the block is idle, unchecked by the block.
// ----------------------------------------------------------------------------
module tick_timebase_with_guarded_reset_unit
  import ttb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] write_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic [5:0]  tokens_held,
  output logic        reset_pending,
  output logic        reset_done
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t      state, state_next;

  // configuration registers
  logic [15:0] ticks_per_second;
  logic [31:0] day_limit;

  // architectural state
  logic [31:0] subsecond_count, subsecond_count_next;
  logic [31:0] second_count, second_count_next;
  logic [5:0]  token_count, token_count_next;
  logic        reset_request, reset_request_next;

  // request held while it is worked on
  req_code_t   req_q;
  logic [31:0] wv_q;
  logic [31:0] sub_inc;
  logic        second_hit;

  logic        in_accept;
  logic        out_take;
  logic        commit;
  logic [31:0] rd_next;
  logic        done_next;

  mod_cmd_t    mod_cmd;
  mod_status_t mod_status;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  // commit once the result register is free or being emptied
  assign commit    = (state == S_FIN) && (!out_valid || !out_stall);

  // start the remainder unit on the incremented sub-second count
  assign mod_cmd.start    = in_accept && (req_code_t'(req_type) == REQ_TICK);
  assign mod_cmd.dividend = subsecond_count + 32'd1;
  assign mod_cmd.divisor  = ticks_per_second;

  ttb_mod_unit u_mod (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mod_cmd),
    .status (mod_status)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
      day_limit        <= DAY_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[15:0];
        CFG_DAY_LIMIT:        day_limit        <= cfg_data;
        default:              ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (req_code_t'(req_type) == REQ_TICK) ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        if (mod_status.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // hold the request and the tick's intermediate values
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_q   <= req_code_t'(req_type);
      wv_q    <= write_value;
      sub_inc <= subsecond_count + 32'd1;
    end
    if (state == S_DIV && mod_status.done) begin
      // a zero divisor never marks a second boundary
      second_hit <= mod_status.rem_zero && (ticks_per_second != 16'd0);
    end
  end

  // request semantics, applied at commit
  always_comb begin
    subsecond_count_next = subsecond_count;
    second_count_next    = second_count;
    token_count_next     = token_count;
    reset_request_next   = reset_request;
    rd_next              = 32'd0;
    done_next            = 1'b0;
    unique case (req_q)
      REQ_TICK: begin
        subsecond_count_next = sub_inc;
        if (second_hit) begin
          second_count_next = second_count + 32'd1;
          if (sub_inc > day_limit) begin
            reset_request_next = 1'b1;
          end
        end
      end
      REQ_READ_SUB, REQ_READ_SEC: begin
        // take a token, saturating
        if (token_count != TOKEN_MAX) begin
          token_count_next = token_count + 6'd1;
        end
        rd_next = (req_q == REQ_READ_SUB) ? subsecond_count : second_count;
      end
      REQ_RELEASE_ONE: begin
        if (token_count != 6'd0) begin
          token_count_next = token_count - 6'd1;
        end
      end
      REQ_RELEASE_ALL: token_count_next = 6'd0;
      REQ_WRITE_SUB:   subsecond_count_next = wv_q;
      REQ_WRITE_SEC:   second_count_next = wv_q;
      REQ_SAFE_RESET: begin
        // clear only with a reset pending and no tokens out
        if (reset_request && token_count == 6'd0) begin
          subsecond_count_next = 32'd0;
          token_count_next     = 6'd0;
          reset_request_next   = 1'b0;
          done_next            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      subsecond_count <= 32'd0;
      second_count    <= 32'd0;
      token_count     <= 6'd0;
      reset_request   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        subsecond_count <= subsecond_count_next;
        second_count    <= second_count_next;
        token_count     <= token_count_next;
        reset_request   <= reset_request_next;
        out_valid       <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      read_value    <= rd_next;
      tokens_held   <= token_count_next;
      reset_pending <= reset_request_next;
      reset_done    <= done_next;
    end
  end

  // a tick always moves into the divide phase
  a_tick_divides: assert property (@(posedge clk) disable iff (rst)
    mod_cmd.start |=> state == S_DIV)
    else $error("tick accepted without starting the remainder phase");

  // the remainder unit finishes only while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    mod_status.done |-> state == S_DIV)
    else $error("remainder done outside the divide phase");

  // a commit always leaves a result in the output register
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid && state == S_IDLE)
    else $error("commit did not produce a result");

  // a completed safe reset leaves no tokens and no pending request
  a_safe_reset_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_done |-> !reset_pending && tokens_held == 6'd0)
    else $error("safe reset reported with tokens or pending flag");

  // the remainder unit is never restarted while busy
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    mod_status.busy |-> !mod_cmd.start)
    else $error("remainder unit restarted while busy");

endmodule
